FILE: rtl/ubds_pkg.sv
// Package for the UART baud divisor search pipeline.
// Holds widths, the oversampling range and the shared pipeline word type.
`timescale 1ns / 1ps
package ubds_pkg;
	localparam int OSR_MIN = 4;
	localparam int OSR_MAX = 32;
	localparam int NUM_OSR = OSR_MAX - OSR_MIN + 1;
	localparam int CLK_W = 28;
	localparam int TGT_W = 23;
	localparam int SBR_W = 16;
	localparam int OSR_W = 6;
	localparam int FAC_W = 7;
	localparam int DEN_W = TGT_W + FAC_W;
	localparam int DIV_STEPS = CLK_W;
	localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(24000000);

	typedef struct packed {
		logic [OSR_W-1:0] osr;
		logic [SBR_W-1:0] sbr;
		logic [CLK_W-1:0] ach;
		logic [CLK_W-1:0] err;
		logic             found;
	} best_t;
endpackage

FILE: rtl/ubds_div.sv
// One radix-2 restoring divider, one quotient bit per pipeline stage.
// Depends on ubds_pkg; every stage holds its own valid bit under a common advance.
`timescale 1ns / 1ps
module ubds_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_vld,
	input  logic [ubds_pkg::CLK_W-1:0]  num,
	input  logic [ubds_pkg::DEN_W-1:0]  den,
	output logic                        out_vld,
	output logic [ubds_pkg::CLK_W-1:0]  quo
);
	import ubds_pkg::*;

	logic                vld_s [DIV_STEPS+1];
	logic [CLK_W-1:0]    num_s [DIV_STEPS+1];
	logic [DEN_W:0]      rem_s [DIV_STEPS+1];
	logic [DEN_W-1:0]    den_s [DIV_STEPS+1];

	assign vld_s[0] = in_vld;
	assign num_s[0] = num;
	assign rem_s[0] = '0;
	assign den_s[0] = den;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [DEN_W:0] sh;
		logic [DEN_W:0] df;
		assign sh = {rem_s[i][DEN_W-1:0], num_s[i][CLK_W-1]};
		assign df = sh - {1'b0, den_s[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				den_s[i+1] <= den_s[i];
				if (!df[DEN_W]) begin
					rem_s[i+1] <= df;
					num_s[i+1] <= {num_s[i][CLK_W-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= sh;
					num_s[i+1] <= {num_s[i][CLK_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld = vld_s[DIV_STEPS];
	assign quo = num_s[DIV_STEPS];
endmodule

FILE: rtl/ubds_lane.sv
// One oversampling lane: divisor divide, product, achieved-rate divide and error.
// Depends on ubds_pkg and ubds_div; the lane latency is fixed for all lanes.
`timescale 1ns / 1ps
module ubds_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_vld,
	input  logic [ubds_pkg::OSR_W-1:0]  osr,
	input  logic [ubds_pkg::CLK_W-1:0]  clock_hz,
	input  logic [ubds_pkg::TGT_W-1:0]  target_baud,
	output ubds_pkg::best_t             cand
);
	import ubds_pkg::*;

	localparam int LAT1 = DIV_STEPS;
	logic [FAC_W-1:0] fac;
	logic [DEN_W-1:0] den1_s1;
	logic [CLK_W-1:0] clk_s1;
	logic [TGT_W-1:0] tgt_s1;
	logic             vld_s1;
	logic             v1;
	logic [CLK_W-1:0] q1;
	logic [CLK_W-1:0] clk_d [LAT1+1];
	logic [TGT_W-1:0] tgt_d [LAT1+1];
	logic [SBR_W-1:0] sbr_s2;
	logic [DEN_W-1:0] den2_s2;
	logic [CLK_W-1:0] clk_s2;
	logic [TGT_W-1:0] tgt_s2;
	logic             vld_s2;
	logic             v2;
	logic [CLK_W-1:0] q2;
	logic [SBR_W-1:0] sbr_d [LAT1+1];
	logic [TGT_W-1:0] tgt_e [LAT1+1];
	logic [CLK_W-1:0] tx;

	assign fac = FAC_W'(osr) + FAC_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= v1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den1_s1 <= DEN_W'(target_baud) * DEN_W'(fac);
			clk_s1 <= clock_hz;
			tgt_s1 <= target_baud;
		end
	end

	ubds_div u_div1 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_vld(vld_s1),
		.num(clk_s1), .den(den1_s1), .out_vld(v1), .quo(q1)
	);

	assign clk_d[0] = clk_s1;
	assign tgt_d[0] = tgt_s1;
	for (genvar i = 0; i < LAT1; i++) begin : g_d1
		always_ff @(posedge clk) begin
			if (adv) begin
				clk_d[i+1] <= clk_d[i];
				tgt_d[i+1] <= tgt_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sbr_s2 <= q1[SBR_W-1:0];
			den2_s2 <= DEN_W'(q1[SBR_W-1:0]) * DEN_W'(fac);
			clk_s2 <= clk_d[LAT1];
			tgt_s2 <= tgt_d[LAT1];
		end
	end

	ubds_div u_div2 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_vld(vld_s2),
		.num(clk_s2), .den(den2_s2), .out_vld(v2), .quo(q2)
	);

	assign sbr_d[0] = sbr_s2;
	assign tgt_e[0] = tgt_s2;
	for (genvar i = 0; i < LAT1; i++) begin : g_d2
		always_ff @(posedge clk) begin
			if (adv) begin
				sbr_d[i+1] <= sbr_d[i];
				tgt_e[i+1] <= tgt_e[i];
			end
		end
	end

	assign tx = CLK_W'(tgt_e[LAT1]);

	always_ff @(posedge clk) begin
		if (adv) begin
			cand.osr <= osr;
			cand.sbr <= sbr_d[LAT1];
			cand.ach <= q2;
			cand.err <= (q2 >= tx) ? (q2 - tx) : (tx - q2);
			cand.found <= v2 && (sbr_d[LAT1] != '0) && (tgt_e[LAT1] != '0);
		end
	end
endmodule

FILE: rtl/ubds_pick.sv
// Registered tree that picks the first candidate with the smallest error.
// Depends on ubds_pkg; the left input wins ties, so lane order is kept.
`timescale 1ns / 1ps
module ubds_pick (
	input  logic                clk,
	input  logic                adv,
	input  ubds_pkg::best_t     cands [ubds_pkg::NUM_OSR],
	output ubds_pkg::best_t     best
);
	import ubds_pkg::*;

	localparam int LVLS = $clog2(NUM_OSR);
	localparam int W = 1 << LVLS;
	best_t lvl [LVLS+1][W];

	function automatic best_t pick2(input best_t a, input best_t b);
		best_t r;
		if (!a.found) begin
			r = b;
		end else if (b.found && b.err < a.err) begin
			r = b;
		end else begin
			r = a;
		end
		return r;
	endfunction

	for (genvar i = 0; i < W; i++) begin : g_leaf
		if (i < NUM_OSR) begin : g_v
			assign lvl[0][i] = cands[i];
		end else begin : g_z
			assign lvl[0][i] = '0;
		end
	end

	for (genvar l = 0; l < LVLS; l++) begin : g_lvl
		for (genvar j = 0; j < (W >> (l + 1)); j++) begin : g_node
			always_ff @(posedge clk) begin
				if (adv) begin
					lvl[l+1][j] <= pick2(lvl[l][2*j], lvl[l][2*j+1]);
				end
			end
		end
		for (genvar j = (W >> (l + 1)); j < W; j++) begin : g_unused
			assign lvl[l+1][j] = '0;
		end
	end

	always_comb begin
		best = lvl[LVLS][0];
		if (!best.found) begin
			best = '0;
		end
	end
endmodule

FILE: rtl/uart_baud_divisor_search.sv
// UART baud divisor search, one target word per cycle through a deep pipeline unless a valid output stalls.
// The depth is set by two pipelined 28-stage dividers per lane, the lane input, middle and output registers
// and the 5-level pick tree. A stall on the output while out_valid is high freezes the whole pipeline;
// the last pick-tree register holds the result. Reset clears valid bits and loads clock_hz with 24000000.
`timescale 1ns / 1ps
module uart_baud_divisor_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ubds_pkg::CLK_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ubds_pkg::TGT_W-1:0]  target_baud,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ubds_pkg::OSR_W-1:0]  best_osr,
	output logic [ubds_pkg::SBR_W-1:0]  best_sbr,
	output logic [ubds_pkg::CLK_W-1:0]  achieved_baud,
	output logic [ubds_pkg::CLK_W-1:0]  baud_error,
	output logic                        found
);
	import ubds_pkg::*;

	localparam int LVLS = $clog2(NUM_OSR);
	localparam int LAT = 2 * DIV_STEPS + 3 + LVLS;

	logic [CLK_W-1:0] clock_hz_q;
	logic             adv;
	logic             vld_s [LAT+1];
	best_t            cands [NUM_OSR];
	best_t            best;

	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLOCK_RESET;
		end else if (cfg_valid) begin
			clock_hz_q <= cfg_data;
		end
	end

	assign vld_s[0] = in_valid;
	for (genvar i = 0; i < LAT; i++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
	end
	assign out_valid = vld_s[LAT];

	for (genvar k = 0; k < NUM_OSR; k++) begin : g_lane
		ubds_lane u_lane (
			.clk(clk), .arst_n(arst_n), .adv(adv), .in_vld(in_valid),
			.osr(OSR_W'(OSR_MIN + k)), .clock_hz(clock_hz_q),
			.target_baud(target_baud), .cand(cands[k])
		);
	end

	ubds_pick u_pick (.clk(clk), .adv(adv), .cands(cands), .best(best));

	assign best_osr = best.osr;
	assign best_sbr = best.sbr;
	assign achieved_baud = best.ach;
	assign baud_error = best.err;
	assign found = best.found;
endmodule
